### design/thi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thi_pkg
// Shared types and constants of the timestamped history interpolator.
// ----------------------------------------------------------------------------
package thi_pkg;

  localparam int unsigned DefDepth = 64;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned FracBits = 16;

  typedef struct packed {
    logic [31:0] ftime;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [2:0]  mstate;
    logic [31:0] seq;
    logic [5:0]  keys;
  } frame_t;

  typedef struct packed {
    logic        is_query;
    frame_t      frame;
    logic [31:0] qtime;
  } req_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic idle;
  } back_stat_t;

endpackage
`default_nettype wire

### design/thi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thi_front
// Request intake: captures a request, classifies it and hands it to the queue.
// ----------------------------------------------------------------------------
module thi_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire logic          mode_i,
  input  wire thi_pkg::frame_t frame_i,
  input  wire logic [31:0]   query_time_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output thi_pkg::req_t      req_o
);
  import thi_pkg::*;

  logic hold_v_q, hold_v_d;
  req_t hold_q;
  logic take;

  assign busy_o = hold_v_q & q_full_i;
  assign take   = start_i & ~busy_o;
  assign push_o = hold_v_q & ~q_full_i;
  assign req_o  = hold_q;
  assign hold_v_d = take | (hold_v_q & ~push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hold_q.is_query <= mode_i;
      hold_q.frame    <= frame_i;
      hold_q.qtime    <= query_time_i;
    end
  end

endmodule
`default_nettype wire

### design/thi_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thi_queue
// Short request queue between intake and execution.
// ----------------------------------------------------------------------------
module thi_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire thi_pkg::req_t req_i,
  input  wire logic          pop_i,
  output thi_pkg::req_t      req_o,
  output logic               empty_o,
  output logic               full_o
);
  import thi_pkg::*;

  localparam int unsigned PW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned NW = $clog2(QDepth + 1);

  req_t          mem_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [NW-1:0] n_q;
  logic          do_push, do_pop;

  assign empty_o = (n_q == '0);
  assign full_o  = (n_q == NW'(QDepth));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign req_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      n_q  <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(QDepth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(QDepth - 1)) ? '0 : rp_q + 1'b1;
      end
      n_q <= n_q + NW'(do_push) - NW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= req_i;
    end
  end

endmodule
`default_nettype wire

### design/thi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thi_back
// Execution: frame ring store, binary search, serial fraction divide and
// shared-multiplier interpolation.
// ----------------------------------------------------------------------------
module thi_back #(
  parameter int unsigned DEPTH = thi_pkg::DefDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire thi_pkg::req_t req_i,
  input  wire logic          q_empty_i,
  output logic               pop_o,
  output logic               valid_o,
  output logic               found_o,
  output thi_pkg::frame_t    res_o,
  output thi_pkg::back_stat_t stat_o
);
  import thi_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_OLD, S_NEW, S_SRCH, S_CMP, S_RDA, S_RDB, S_DIV, S_MUL, S_ADD
  } state_e;

  state_e        state_q;
  logic [AW-1:0] oldest_q, lo_q, hi_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   qt_q;
  frame_t        a_q, b_q, rd_q, res_q;
  logic [31:0]   rem_q, den_q;
  logic [16:0]   alpha_q;
  logic [4:0]    step_q;
  logic [1:0]    axis_q;
  logic signed [50:0] prod_q;
  logic          valid_q, found_q;

  frame_t        mem [DEPTH];

  logic [AW-1:0] rd_idx, rd_slot, wr_slot, mid, span;
  logic          wr_en, full;
  logic [32:0]   dv_t;
  logic          dv_ge;
  logic [31:0]   av, bv, sum;
  logic signed [32:0] diff;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] idx);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, idx};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign full = (cnt_q == CW'(DEPTH));
  assign span = hi_q - lo_q;
  assign mid  = lo_q + (span >> 1);

  always_comb begin
    case (state_q)
      S_OLD:   rd_idx = AW'(cnt_q - 1'b1);
      S_SRCH:  rd_idx = (span > AW'(1)) ? mid : lo_q;
      S_RDA:   rd_idx = hi_q;
      default: rd_idx = '0;
    endcase
  end

  assign rd_slot = slot_of(oldest_q, rd_idx);
  assign wr_slot = full ? oldest_q : slot_of(oldest_q, AW'(cnt_q));
  assign pop_o   = (state_q == S_IDLE) & ~q_empty_i;
  assign wr_en   = pop_o & ~req_i.is_query;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_slot] <= req_i.frame;
    end
    rd_q <= mem[rd_slot];
  end

  // one quotient bit per cycle; the first step takes the integer bit
  assign dv_t  = (step_q == 5'd16) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign dv_ge = (dv_t >= {1'b0, den_q});

  always_comb begin
    case (axis_q)
      2'd0:    begin av = a_q.x; bv = b_q.x; end
      2'd1:    begin av = a_q.y; bv = b_q.y; end
      default: begin av = a_q.z; bv = b_q.z; end
    endcase
  end
  assign diff = $signed({bv[31], bv}) - $signed({av[31], av});
  assign sum  = av + prod_q[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      oldest_q <= '0;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
      found_q  <= 1'b0;
      lo_q     <= '0;
      hi_q     <= '0;
      step_q   <= '0;
      axis_q   <= '0;
      qt_q     <= '0;
      a_q      <= '0;
      b_q      <= '0;
      res_q    <= '0;
      rem_q    <= '0;
      den_q    <= '0;
      alpha_q  <= '0;
      prod_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            if (!req_i.is_query) begin
              if (full) begin
                oldest_q <= (oldest_q == AW'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
              end else begin
                cnt_q <= cnt_q + 1'b1;
              end
            end else begin
              qt_q <= req_i.qtime;
              if (cnt_q == '0) begin
                valid_q <= 1'b1;
                found_q <= 1'b0;
                res_q   <= '0;
              end else begin
                state_q <= S_OLD;
              end
            end
          end
        end
        S_OLD: begin
          if (qt_q <= rd_q.ftime) begin
            valid_q <= 1'b1;
            found_q <= 1'b1;
            res_q   <= rd_q;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_NEW;
          end
        end
        S_NEW: begin
          if (qt_q >= rd_q.ftime) begin
            valid_q <= 1'b1;
            found_q <= 1'b1;
            res_q   <= rd_q;
            state_q <= S_IDLE;
          end else begin
            lo_q    <= '0;
            hi_q    <= AW'(cnt_q - 1'b1);
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          state_q <= (span > AW'(1)) ? S_CMP : S_RDA;
        end
        S_CMP: begin
          if (rd_q.ftime < qt_q) lo_q <= mid;
          else hi_q <= mid;
          state_q <= S_SRCH;
        end
        S_RDA: begin
          a_q     <= rd_q;
          state_q <= S_RDB;
        end
        S_RDB: begin
          b_q     <= rd_q;
          rem_q   <= qt_q - a_q.ftime;
          den_q   <= rd_q.ftime - a_q.ftime;
          alpha_q <= '0;
          step_q  <= 5'd16;
          state_q <= S_DIV;
        end
        S_DIV: begin
          alpha_q <= {alpha_q[15:0], dv_ge};
          rem_q   <= dv_ge ? 32'(dv_t - {1'b0, den_q}) : dv_t[31:0];
          if (step_q == '0) begin
            axis_q  <= '0;
            state_q <= S_MUL;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        S_MUL: begin
          prod_q  <= diff * $signed({1'b0, alpha_q});
          state_q <= S_ADD;
        end
        S_ADD: begin
          case (axis_q)
            2'd0:    res_q.x <= sum;
            2'd1:    res_q.y <= sum;
            default: res_q.z <= sum;
          endcase
          if (axis_q == 2'd2) begin
            valid_q      <= 1'b1;
            found_q      <= 1'b1;
            res_q.ftime  <= qt_q;
            res_q.mstate <= a_q.mstate;
            res_q.seq    <= a_q.seq;
            res_q.keys   <= a_q.keys;
            state_q      <= S_IDLE;
          end else begin
            axis_q  <= axis_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign valid_o = valid_q;
  assign found_o = found_q;
  assign res_o   = res_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = full;
  assign stat_o.idle  = (state_q == S_IDLE);

endmodule
`default_nettype wire

### design/timestamped_history_interpolator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timestamped_history_interpolator_top
// Ring of the last DEPTH frames with time lookup and linear interpolation.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; mode_i=0 records
// a frame (no result), mode_i=1 queries at query_time_i and gives one result,
// shown for one cycle with valid_o, which the receiver cannot hold off.
// Requests pass through a two-entry queue to the execution unit, which handles
// one at a time. A record passes the intake hold register and the queue before
// it is written to the frame store. A query on an empty ring is answered with a
// miss, and one at or outside the stored span with the oldest or newest frame,
// without a search; an interpolated query is paced by the single read port of
// the frame store during the search, the 17-step serial divide and one shared
// multiplier over the three axes.
// No clearing pass after reset.
module timestamped_history_interpolator_top #(
  parameter int unsigned DEPTH = thi_pkg::DefDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               mode_i,
  input  wire logic [31:0]        frame_time_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic [2:0]         motion_state_i,
  input  wire logic [31:0]        sequence_req_i,
  input  wire logic [5:0]         key_bits_i,
  input  wire logic [31:0]        query_time_i,
  output logic                    valid_o,
  output logic                    found_o,
  output logic [31:0]             out_time_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  output logic [2:0]              out_state_o,
  output logic [31:0]             out_sequence_o,
  output logic [5:0]              out_keys_o
);
  import thi_pkg::*;

  frame_t     in_frame, res;
  req_t       f_req, q_req;
  logic       push, pop, q_empty, q_full;
  back_stat_t stat;

  assign in_frame.ftime  = frame_time_i;
  assign in_frame.x      = pos_x_i;
  assign in_frame.y      = pos_y_i;
  assign in_frame.z      = pos_z_i;
  assign in_frame.mstate = motion_state_i;
  assign in_frame.seq    = sequence_req_i;
  assign in_frame.keys   = key_bits_i;

  thi_front u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i,
    .frame_i(in_frame), .query_time_i, .q_full_i(q_full),
    .push_o(push), .req_o(f_req)
  );

  thi_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .req_i(f_req), .pop_i(pop),
    .req_o(q_req), .empty_o(q_empty), .full_o(q_full)
  );

  thi_back #(.DEPTH(DEPTH)) u_back (
    .clk_i, .rst_ni, .req_i(q_req), .q_empty_i(q_empty), .pop_o(pop),
    .valid_o, .found_o, .res_o(res), .stat_o(stat)
  );

  assign out_time_o     = res.ftime;
  assign out_x_o        = res.x;
  assign out_y_o        = res.y;
  assign out_z_o        = res.z;
  assign out_state_o    = res.mstate;
  assign out_sequence_o = res.seq;
  assign out_keys_o     = res.keys;

`ifndef SYNTH
  a_found_needs_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && found_o |-> !stat.empty)
    else $error("result found with empty ring");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !found_o |-> out_time_o == '0 && out_x_o == '0 && out_keys_o == '0)
    else $error("miss result not cleared");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> stat.idle && !q_empty)
    else $error("request taken while execution busy");
`endif

endmodule
`default_nettype wire

### dv/thi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thi_checker
// Watches the request and result channels of the history interpolator, keeps
// its own copy of the frame ring, works out each query answer and compares.
// ----------------------------------------------------------------------------
module thi_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               busy_o,
  input  wire logic               mode_i,
  input  wire logic [31:0]        frame_time_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic [2:0]         motion_state_i,
  input  wire logic [31:0]        sequence_req_i,
  input  wire logic [5:0]         key_bits_i,
  input  wire logic [31:0]        query_time_i,
  input  wire logic               valid_o,
  input  wire logic               found_o,
  input  wire logic [31:0]        out_time_o,
  input  wire logic signed [31:0] out_x_o,
  input  wire logic signed [31:0] out_y_o,
  input  wire logic signed [31:0] out_z_o,
  input  wire logic [2:0]         out_state_o,
  input  wire logic [31:0]        out_sequence_o,
  input  wire logic [5:0]         out_keys_o,
  output int                      errors_o,
  output int                      pending_o,
  output int                      answers_o,
  output int                      blended_o
);
  import thi_pkg::*;

  localparam int DueDepth = 16;

  typedef struct packed {
    logic        found;
    frame_t      frame;
  } answer_t;

  frame_t  ring[DEPTH];
  int      head;
  int      count;
  // answers still owed by the block, oldest at due_rd
  answer_t due_buf[DueDepth];
  int      due_rd;
  int      due_wr;

  assign pending_o = due_wr - due_rd;

  function automatic int slot(int i);
    return (head + i) % DEPTH;
  endfunction

  // a + floor((b - a) * alpha / 2^16), exact in 64 bits
  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [31:0] alpha);
    longint sa;
    longint prod;
    sa   = longint'($signed(a));
    prod = (longint'($signed(b)) - sa) * longint'(alpha);
    return 32'(sa + (prod >>> 16));
  endfunction

  task automatic lookup(input logic [31:0] q);
    answer_t r;
    frame_t  fa;
    frame_t  fb;
    int      lo;
    int      hi;
    int      mid;
    logic [63:0] alpha;
    r = '0;
    if (count > 0) begin
      r.found = 1'b1;
      if (q <= ring[slot(0)].ftime) begin
        r.frame = ring[slot(0)];
      end else if (q >= ring[slot(count - 1)].ftime) begin
        r.frame = ring[slot(count - 1)];
      end else begin
        lo = 0;
        hi = count - 1;
        while (hi - lo > 1) begin
          mid = lo + (hi - lo) / 2;
          if (ring[slot(mid)].ftime < q) lo = mid;
          else hi = mid;
        end
        fa = ring[slot(lo)];
        fb = ring[slot(hi)];
        alpha = (64'(q - fa.ftime) << 16) / 64'(fb.ftime - fa.ftime);
        r.frame = fa;
        r.frame.ftime = q;
        r.frame.x = blend(fa.x, fb.x, alpha[31:0]);
        r.frame.y = blend(fa.y, fb.y, alpha[31:0]);
        r.frame.z = blend(fa.z, fb.z, alpha[31:0]);
        blended_o++;
      end
    end
    if (due_wr - due_rd >= DueDepth) begin
      $display("%0t: more queries outstanding than the checker can hold", $time);
      errors_o++;
    end else begin
      due_buf[due_wr % DueDepth] = r;
      due_wr++;
    end
  endtask

  task automatic cmp(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
      errors_o++;
    end
  endtask

  initial begin
    errors_o  = 0;
    answers_o = 0;
    blended_o = 0;
    head      = 0;
    count     = 0;
    due_rd    = 0;
    due_wr    = 0;
  end

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni) begin
      if (valid_o) begin
        answers_o++;
        if (due_wr == due_rd) begin
          $display("%0t: result with no query outstanding", $time);
          errors_o++;
        end else begin
          e = due_buf[due_rd % DueDepth];
          due_rd++;
          cmp("found", 32'(e.found), 32'(found_o));
          cmp("time", e.frame.ftime, out_time_o);
          cmp("x", e.frame.x, out_x_o);
          cmp("y", e.frame.y, out_y_o);
          cmp("z", e.frame.z, out_z_o);
          cmp("state", 32'(e.frame.mstate), 32'(out_state_o));
          cmp("sequence", e.frame.seq, out_sequence_o);
          cmp("keys", 32'(e.frame.keys), 32'(out_keys_o));
        end
      end
      if (start_i && !busy_o) begin
        if (mode_i) begin
          lookup(query_time_i);
        end else if (count < DEPTH) begin
          ring[slot(count)] = '{frame_time_i, pos_x_i, pos_y_i, pos_z_i,
                                motion_state_i, sequence_req_i, key_bits_i};
          count++;
        end else begin
          ring[head] = '{frame_time_i, pos_x_i, pos_y_i, pos_z_i,
                         motion_state_i, sequence_req_i, key_bits_i};
          head = (head + 1) % DEPTH;
        end
      end
    end
  end
endmodule

### dv/tb_timestamped_history_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamped_history_interpolator_top
// Drives record and query requests into the history interpolator: a directed
// set of edge cases, then random frame streams with queries inside and around
// the stored span, under three idling profiles.
// ----------------------------------------------------------------------------
module tb_timestamped_history_interpolator_top;
  import thi_pkg::*;

  localparam int unsigned DEPTH = DefDepth;
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;
  localparam int CYCLE_LIMIT   = 600000;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               mode_i;
  logic [31:0]        frame_time_i;
  logic signed [31:0] pos_x_i;
  logic signed [31:0] pos_y_i;
  logic signed [31:0] pos_z_i;
  logic [2:0]         motion_state_i;
  logic [31:0]        sequence_req_i;
  logic [5:0]         key_bits_i;
  logic [31:0]        query_time_i;
  logic               valid_o;
  logic               found_o;
  logic [31:0]        out_time_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic [2:0]         out_state_o;
  logic [31:0]        out_sequence_o;
  logic [5:0]         out_keys_o;
  int                 errors;
  int                 pending;
  int                 answers;
  int                 blended;
  int                 cycles;
  int                 idle_pct;
  int                 requests;
  logic [31:0]        last_time;
  logic [31:0]        span_lo;

  timestamped_history_interpolator_top #(.DEPTH(DEPTH)) DUT (.*);

  thi_checker #(.DEPTH(DEPTH)) u_checker (
    .*,
    .errors_o (errors),
    .pending_o(pending),
    .answers_o(answers),
    .blended_o(blended)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one request, with random idle cycles in front of it
  task automatic issue(input logic m, input logic [31:0] t, input logic [31:0] x,
                       input logic [31:0] y, input logic [31:0] z, input logic [31:0] q);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    mode_i         <= m;
    frame_time_i   <= t;
    pos_x_i        <= x;
    pos_y_i        <= y;
    pos_z_i        <= z;
    motion_state_i <= 3'($urandom);
    sequence_req_i <= $urandom;
    key_bits_i     <= 6'($urandom);
    query_time_i   <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    requests++;
  endtask

  task automatic record(input logic [31:0] t);
    issue(MODE_RECORD, t, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic query(input logic [31:0] q);
    issue(MODE_QUERY, $urandom, $urandom, $urandom, $urandom, q);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // a stream of mostly increasing frames, some at random times, with queries scattered through and beyond it
  task automatic random_burst(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          last_time = last_time + $urandom_range($urandom_range(1) ? 3 : 200000);
          record(last_time);
        end
        4: record($urandom);
        5: query($urandom);
        6: query(span_lo);
        7: query(last_time);
        default: query(span_lo + $urandom_range(last_time - span_lo));
      endcase
    end
  endtask

  initial begin
    int k;
    cycles = 0;
    requests = 0;
    idle_pct = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    mode_i = MODE_RECORD;
    frame_time_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    motion_state_i = '0;
    sequence_req_i = '0;
    key_bits_i = '0;
    query_time_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty ring, single frame, extremes, exact bracket hits
    query(32'h0);
    query(32'hFFFF_FFFF);
    issue(MODE_RECORD, 32'h0000_1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    query(32'h0);
    query(32'hFFFF_FFFF);
    issue(MODE_RECORD, 32'h0000_2000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    query(32'h0000_1800);
    query(32'h0000_2000);
    query(32'h0000_1001);
    query(32'h0000_1fff);
    issue(MODE_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
    query(32'hFFFF_FFFE);
    query(32'h8000_0000);
    // unordered: a time below the earlier frames
    record(32'h0000_0800);
    query(32'h0000_1800);
    query(32'h0000_0800);
    drain();

    // fill past DEPTH so the ring wraps
    last_time = 32'h0000_3000;
    span_lo = last_time;
    for (k = 0; k < DEPTH + 10; k++) begin
      last_time = last_time + $urandom_range(1, 4000);
      record(last_time);
      if (k == 10) span_lo = last_time;
    end
    query(span_lo + 1);
    query(last_time - 1);

    idle_pct = 20;
    random_burst(650);
    drain();
    idle_pct = 55;
    random_burst(600);
    drain();
    idle_pct = 0;
    random_burst(600);
    drain();

    $display("%0d requests, %0d answers, %0d interpolated, ring wrapped with DEPTH %0d",
             requests, answers, blended, DEPTH);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
